// File: hw/rtl/b32h_pkg.sv
// ----------------------------------------------------------------------------
// b32h_pkg: shared types and constants for the base32hex stream decoder
// Payload structs, the job record between front and back, and the character
// tables of the extended-hex alphabet.
// ----------------------------------------------------------------------------
package b32h_pkg;

  // Reset values of the configuration registers.
  localparam logic [7:0] PAD_RESET = 8'd61;  // '='
  localparam logic [7:0] SEP_RESET = 8'd10;  // newline

  // Alphabet bounds.
  localparam logic [7:0] CH_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_V = 8'h56;  // 'V'
  localparam logic [7:0] DIGIT_LETTER_BASE = 8'd10;

  // Jobs buffered between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_PAD = 1'b0,
    CFG_SEP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } char_word_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_data;
    logic       run_last;
    logic       stream_end;
    logic       bad_length;
    logic       bad_char;
  } byte_word_t;

  // One input's worth of output work: up to five bytes, most significant
  // byte at the top of data, optionally followed by a stream end marker.
  typedef struct packed {
    logic [39:0] data;
    logic [2:0]  nbytes;
    logic        marker;
    logic        bad_length;
    logic        bad_char;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] value;
  } decode_t;

  function automatic decode_t char_decode(logic [7:0] c);
    decode_t d;
    d.ok    = 1'b1;
    d.value = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d.value = 5'(c - CH_0);
    end else if (c >= CH_A && c <= CH_V) begin
      d.value = 5'(c - CH_A + DIGIT_LETTER_BASE);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  // Bytes produced by a partial group of the given character count.
  function automatic logic [2:0] grp_bytes(logic [2:0] cnt);
    logic [2:0] n;
    unique case (cnt)
      3'd2:    n = 3'd1;
      3'd4:    n = 3'd2;
      3'd5:    n = 3'd3;
      3'd7:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Group lengths that cannot come from whole bytes.
  function automatic logic grp_bad(logic [2:0] cnt);
    return (cnt == 3'd1) || (cnt == 3'd3) || (cnt == 3'd6);
  endfunction

endpackage

// File: hw/rtl/b32h_front.sv
// ----------------------------------------------------------------------------
// b32h_front: character intake and classification
// Holds the bit buffer and stream state, and turns each accepted character
// into at most one job for the output side.
// ----------------------------------------------------------------------------
module b32h_front import b32h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_reg_t   cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [7:0]  pad_char;
  logic [7:0]  separator_char;
  logic [34:0] bit_buffer;
  logic [2:0]  char_count;
  logic        skipping;
  logic        saw_bad_char;
  logic        saw_bad_length;

  logic [34:0] bit_buffer_next;
  logic [2:0]  char_count_next;
  logic        skipping_next;
  logic        saw_bad_char_next;
  logic        saw_bad_length_next;

  logic        accept;
  logic        sep_hit;
  logic        pad_hit;
  decode_t     dec;
  logic        fl_bad;
  logic [2:0]  fl_n;
  logic [5:0]  fl_shift;
  logic [39:0] fl_data;

  assign cfg_ready  = 1'b1;
  assign char_stall = queue_full;
  assign accept     = char_valid && !char_stall;

  assign sep_hit = char_word.end_of_input || (char_word.char_code == separator_char);
  assign pad_hit = char_word.char_code == pad_char;
  assign dec     = char_decode(char_word.char_code);

  // Partial group flush: left-align the pending bits, the top bytes are output.
  assign fl_bad   = grp_bad(char_count);
  assign fl_n     = fl_bad ? 3'd0 : grp_bytes(char_count);
  assign fl_shift = 6'd35 - ({3'd0, char_count} << 2) - {3'd0, char_count};
  assign fl_data  = {bit_buffer, 5'd0} << fl_shift;

  always_comb begin
    bit_buffer_next     = bit_buffer;
    char_count_next     = char_count;
    skipping_next       = skipping;
    saw_bad_char_next   = saw_bad_char;
    saw_bad_length_next = saw_bad_length;
    push                = 1'b0;
    push_job            = '0;
    priority if (sep_hit) begin
      push                = 1'b1;
      push_job.data       = fl_data;
      push_job.nbytes     = skipping ? 3'd0 : fl_n;
      push_job.marker     = 1'b1;
      push_job.bad_length = saw_bad_length || (!skipping && fl_bad);
      push_job.bad_char   = saw_bad_char;
      bit_buffer_next     = '0;
      char_count_next     = '0;
      skipping_next       = 1'b0;
      saw_bad_char_next   = 1'b0;
      saw_bad_length_next = 1'b0;
    end else if (skipping) begin
      push = 1'b0;
    end else if (pad_hit || !dec.ok) begin
      push                = fl_n != 3'd0;
      push_job.data       = fl_data;
      push_job.nbytes     = fl_n;
      bit_buffer_next     = '0;
      char_count_next     = '0;
      skipping_next       = 1'b1;
      saw_bad_length_next = saw_bad_length || fl_bad;
      saw_bad_char_next   = saw_bad_char || !pad_hit;
    end else if (char_count == 3'd7) begin
      push            = 1'b1;
      push_job.data   = {bit_buffer, dec.value};
      push_job.nbytes = 3'd5;
      bit_buffer_next = '0;
      char_count_next = '0;
    end else begin
      bit_buffer_next = {bit_buffer[29:0], dec.value};
      char_count_next = char_count + 3'd1;
    end
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_char       <= PAD_RESET;
      separator_char <= SEP_RESET;
      bit_buffer     <= '0;
      char_count     <= '0;
      skipping       <= 1'b0;
      saw_bad_char   <= 1'b0;
      saw_bad_length <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PAD: pad_char       <= cfg_data;
          CFG_SEP: separator_char <= cfg_data;
        endcase
      end
      if (accept) begin
        bit_buffer     <= bit_buffer_next;
        char_count     <= char_count_next;
        skipping       <= skipping_next;
        saw_bad_char   <= saw_bad_char_next;
        saw_bad_length <= saw_bad_length_next;
      end
    end
  end

endmodule

// File: hw/rtl/b32h_queue.sv
// ----------------------------------------------------------------------------
// b32h_queue: job queue between front and back
// A small first-in first-out buffer of job records.
// ----------------------------------------------------------------------------
module b32h_queue import b32h_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("job popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

// File: hw/rtl/b32h_back.sv
// ----------------------------------------------------------------------------
// b32h_back: result sequencer
// Takes jobs from the queue and emits their bytes and markers one word per
// cycle, while byte_stall allows, through a registered output stage.
// ----------------------------------------------------------------------------
module b32h_back import b32h_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  job_t       q_head,
  output logic       pop,
  output logic       byte_valid,
  input  logic       byte_stall,
  output byte_word_t byte_word
);

  job_t       cur;
  logic       cur_valid;
  logic       out_free;
  logic       emit;
  logic       cur_last;
  byte_word_t item;

  assign out_free = !byte_valid || !byte_stall;
  assign emit     = cur_valid && out_free;
  assign cur_last = (cur.nbytes == 3'd0) || ((cur.nbytes == 3'd1) && !cur.marker);
  assign pop      = q_not_empty && (!cur_valid || (emit && cur_last));

  always_comb begin
    item = '0;
    if (cur.nbytes != 3'd0) begin
      item.byte_value = cur.data[39:32];
      item.is_data    = 1'b1;
      item.run_last   = cur_last;
    end else begin
      item.stream_end = 1'b1;
      item.run_last   = 1'b1;
      item.bad_length = cur.bad_length;
      item.bad_char   = cur.bad_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (emit && cur_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end else if (emit) begin
      cur.data   <= {cur.data[31:0], 8'd0};
      cur.nbytes <= cur.nbytes - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (out_free) begin
      byte_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      byte_word <= item;
    end
  end

`ifndef SYNTHESIS
  a_marker_closes_run: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_word.is_data |-> byte_word.run_last && byte_word.stream_end)
    else $error("stream end marker without run_last");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_word.is_data |->
      !byte_word.stream_end && !byte_word.bad_length && !byte_word.bad_char)
    else $error("data word carries marker flags");

  a_job_size: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.nbytes <= 3'd5)
    else $error("job holds more than five bytes");

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_head.marker || (q_head.nbytes != 3'd0))
    else $error("job without any result word");
`endif

endmodule

// File: hw/rtl/base32hex_stream_decoder.sv
// ----------------------------------------------------------------------------
// base32hex_stream_decoder: streaming base32hex (extended-hex) decoder
// Decodes characters into bytes and closes each stream with a marker word.
// ----------------------------------------------------------------------------
// One character word is accepted per cycle as long as the job queue between
// the intake and the result side has room. The intake keeps a 35-bit bit
// buffer and a group count; every eighth legal character ('0'-'9', 'A'-'V')
// makes a job of five bytes, and a pad, an illegal character, the separator
// or end_of_input flushes the partial group (2, 4, 5 or 7 characters give 1,
// 2, 3 or 4 bytes, while 1, 3 or 6 give none and set bad_length on the
// marker). A separator or end_of_input always ends in a marker word with
// stream_end set; after a pad or an illegal character, characters are
// dropped until that marker. The result side emits one word per cycle, while
// byte_stall allows, from a registered output stage; a full group of eight
// characters gives five words, so a continuous character stream runs at one
// character per cycle while the output is drained every cycle. The queue
// holds QDEPTH jobs (QUEUE_DEPTH by default); the first word of a job goes
// through the queue, the current-job register and the output register.
// run_last marks the final word caused by each input. Configuration
// registers (index 0 pad character, index 1 separator) are written through
// the cfg port, which is always ready; write them only while the block is
// idle.
// ----------------------------------------------------------------------------
module base32hex_stream_decoder import b32h_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  output logic       byte_valid,
  input  logic       byte_stall,
  output byte_word_t byte_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_reg_t   cfg_index,
  input  logic [7:0] cfg_data
);

  // Jobs flow from the intake into the queue and out to the sequencer.
  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic q_not_empty;
  job_t q_head;

  b32h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  b32h_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b32h_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word)
  );

endmodule

// File: tb/sv/base32hex_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// base32hex_stream_decoder_tb: self-checking testbench for the decoder
// A directed table walks the alphabet edges, pads, illegal characters, bad
// group lengths and empty streams. Random streams then run under several
// pad and separator settings. Every word from the block is checked field by
// field against a cycle-free model of the decoder kept in this bench.
// ----------------------------------------------------------------------------
module base32hex_stream_decoder_tb;
  import b32h_pkg::*;

  // Cycles with no accepted word on any channel before the run is called hung.
  // The longest honest quiet stretch is the deliberate receiver hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  // The first word of a job passes the queue and the output register after its
  // character; the settle wait also covers characters that cause no word at all.
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 58;
  localparam int NUM_PHASES     = 6;

  // Pad and separator for each phase as {pad, sep}. The last phase is random.
  localparam logic [15:0] PHASE_CFG [0:NUM_PHASES-2] = '{
    16'h3D0A,  // the reset values, written explicitly
    16'h00FF,  // both extremes
    16'hFF00,  // both extremes, swapped
    16'h2E2E,  // pad equal to separator, so the separator must win
    16'h4130   // pad 'A' and separator '0', both taken out of the alphabet
  };

  // One row of the directed table. Rows with typed set expect exactly one
  // marker word with the given flags; all other rows go through the model.
  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
    logic       typed;
    logic       blen;
    logic       bchar;
  } dir_row_t;

  localparam int NUM_DIRECTED = 27;
  localparam dir_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
    '{8'h0A, 1'b0, 1'b1, 1'b0, 1'b0},  // separator right after reset
    '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0},  // end of input straight after a marker
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},    // eight 'V' make five 0xFF bytes
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"0", 1'b0, 1'b0, 1'b0, 1'b0},    // a lone character is a bad length
    '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
    '{"9", 1'b0, 1'b0, 1'b0, 1'b0},    // both ends of the digit/letter gap
    '{"A", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"=", 1'b0, 1'b0, 1'b0, 1'b0},    // pad flushes one byte, then skips
    '{"a", 1'b0, 1'b0, 1'b0, 1'b0},    // lowercase while skipping: dropped
    '{8'h0A, 1'b0, 1'b1, 1'b0, 1'b0},
    '{":", 1'b0, 1'b0, 1'b0, 1'b0},    // between '9' and 'A': illegal
    '{8'h0A, 1'b0, 1'b1, 1'b0, 1'b1},
    '{"U", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"V", 1'b0, 1'b0, 1'b0, 1'b0},
    '{"W", 1'b0, 1'b0, 1'b0, 1'b0},    // just above 'V': illegal after a pair
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0},  // dropped while skipping
    '{8'h55, 1'b1, 1'b1, 1'b0, 1'b1},  // code is ignored on end of input
    '{"K", 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0},  // illegal after one character
    '{8'h0A, 1'b0, 1'b1, 1'b1, 1'b1}   // both flags on one marker
  };

  logic       clk;
  logic       rst        = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  char_word_t char_word  = '0;
  logic       byte_valid;
  logic       byte_stall = 1'b0;
  byte_word_t byte_word;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  cfg_reg_t   cfg_index  = CFG_PAD;
  logic [7:0] cfg_data   = '0;

  base32hex_stream_decoder DUT (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder model. It mirrors the block's state and configuration and turns
  // each accepted character word into the byte words it must cause.
  // ---------------------------------------------------------------------------
  logic [7:0]  pad_code     = PAD_RESET;
  logic [7:0]  sep_code     = SEP_RESET;
  logic [34:0] grp_bits     = '0;
  logic [2:0]  grp_len      = '0;
  logic        dropping     = 1'b0;
  logic        bad_char_seen = 1'b0;
  logic        bad_len_seen  = 1'b0;

  // Byte words still owed by the block, oldest first.
  byte_word_t owed_bytes [$];

  int  mismatches  = 0;
  int  counted     = 0;   // character words in this phase that did real work
  bit  tx_quiet    = 1'b0;
  bit  rx_quiet    = 1'b0;
  int  hold_asks   = 0;   // bumped by the stimulus to ask for a long hold-off

  // Append one word at the young end of the owed list.
  task automatic owe_word(byte_word_t w);
    owed_bytes = {owed_bytes, w};
  endtask

  // Queue n bytes taken from the low end of val, most significant first.
  task automatic owe_bytes(logic [39:0] val, int n);
    byte_word_t w;
    for (int i = 0; i < n; i++) begin
      w            = '0;
      w.byte_value = 8'(val >> (8 * (n - 1 - i)));
      w.is_data    = 1'b1;
      owe_word(w);
    end
  endtask

  // Close out a partial group. Whole bytes survive; the leftover bits that
  // never completed a byte are dropped off the bottom of the buffer.
  task automatic flush_partial();
    int nbytes;
    int drop;
    case (grp_len)
      3'd2: begin
        nbytes = 1;
        drop   = 2;
      end
      3'd4: begin
        nbytes = 2;
        drop   = 4;
      end
      3'd5: begin
        nbytes = 3;
        drop   = 1;
      end
      3'd7: begin
        nbytes = 4;
        drop   = 3;
      end
      default: begin
        nbytes = 0;
        drop   = 0;
      end
    endcase
    if (grp_len == 3'd1 || grp_len == 3'd3 || grp_len == 3'd6) begin
      bad_len_seen = 1'b1;
    end else if (nbytes > 0) begin
      owe_bytes(40'(grp_bits >> drop), nbytes);
    end
    grp_bits = '0;
    grp_len  = '0;
  endtask

  // Advance the model by one accepted character word. ignored comes back set
  // when the word was swallowed by a stopped stream and changed nothing.
  task automatic decode_char(char_word_t w, output bit ignored);
    int         owed_before;
    logic [4:0] sym;
    logic       legal;
    byte_word_t tail;
    owed_before = owed_bytes.size();
    ignored     = 1'b0;
    // The separator is tested before the pad, so it wins when they match.
    if (w.end_of_input || w.char_code == sep_code) begin
      if (!dropping) begin
        flush_partial();
      end
      tail            = '0;
      tail.stream_end = 1'b1;
      tail.bad_length = bad_len_seen;
      tail.bad_char   = bad_char_seen;
      owe_word(tail);
      grp_bits      = '0;
      grp_len       = '0;
      dropping      = 1'b0;
      bad_char_seen = 1'b0;
      bad_len_seen  = 1'b0;
    end else if (dropping) begin
      ignored = 1'b1;
    end else if (w.char_code == pad_code) begin
      flush_partial();
      dropping = 1'b1;
    end else begin
      legal = 1'b1;
      sym   = '0;
      if (w.char_code >= CH_0 && w.char_code <= CH_9) begin
        sym = 5'(w.char_code - CH_0);
      end else if (w.char_code >= CH_A && w.char_code <= CH_V) begin
        sym = 5'(w.char_code - CH_A + 8'd10);
      end else begin
        legal = 1'b0;
      end
      if (!legal) begin
        flush_partial();
        dropping      = 1'b1;
        bad_char_seen = 1'b1;
      end else if (grp_len == 3'd7) begin
        owe_bytes({grp_bits, sym}, 5);
        grp_bits = '0;
        grp_len  = '0;
      end else begin
        grp_bits = {grp_bits[29:0], sym};
        grp_len  = grp_len + 3'd1;
      end
    end
    // The last word caused by this character carries run_last.
    if (owed_bytes.size() > owed_before) begin
      tail          = owed_bytes.pop_back();
      tail.run_last = 1'b1;
      owe_word(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Each word waits a random gap with valid low, then is held
  // until the block takes it. Valid stays high across back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_word(char_word_t w, bit typed = 1'b0, byte_word_t typed_word = '0);
    int gap;
    int owed_mark;
    bit ignored;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    do @(posedge clk); while (char_stall);
    owed_mark = owed_bytes.size();
    decode_char(w, ignored);
    // A typed row replaces what the model predicted with the hand-written
    // marker, while the model's state still moves on.
    if (typed) begin
      while (owed_bytes.size() > owed_mark) void'(owed_bytes.pop_back());
      owe_word(typed_word);
    end
    if (!ignored) begin
      counted++;
    end
  endtask

  function automatic logic [7:0] alpha_char(logic [4:0] sym);
    return (sym < 5'd10) ? 8'(CH_0 + sym) : 8'(CH_A + sym - 5'd10);
  endfunction

  task automatic send_char(logic [7:0] code);
    send_word('{char_code: code, end_of_input: 1'b0});
  endtask

  // Close a stream with either the separator or end of input.
  task automatic send_close();
    if ($urandom_range(0, 1) == 0) begin
      send_char(sep_code);
    end else begin
      send_word('{char_code: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
    end
  endtask

  // One random stream. Most are well formed with random content, so that
  // every group length and the full-group path get exercised; the rest are
  // broken by a stray byte or are plain noise.
  task automatic send_stream();
    int kind;
    int nchars;
    kind     = $urandom_range(0, 9);
    tx_quiet = ($urandom_range(0, 4) == 0);
    nchars   = $urandom_range(0, 17);
    if (kind <= 6) begin
      repeat (nchars) send_char(alpha_char(5'($urandom_range(0, 31))));
      if ($urandom_range(0, 2) == 0) begin
        send_char(pad_code);
        repeat ($urandom_range(0, 3)) begin
          send_char(($urandom_range(0, 1) == 0) ? pad_code : 8'($urandom_range(0, 255)));
        end
      end
      send_close();
    end else if (kind <= 8) begin
      repeat (nchars) send_char(alpha_char(5'($urandom_range(0, 31))));
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
      send_close();
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_word('{char_code: 8'($urandom_range(0, 255)),
                    end_of_input: ($urandom_range(0, 7) == 0)});
      end
    end
  endtask

  // Drop valid and wait until every owed byte word has been taken.
  task automatic drain();
    char_valid <= 1'b0;
    while (owed_bytes.size() != 0) @(posedge clk);
  endtask

  // Registers are written only once the block has gone quiet.
  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PAD) begin
      pad_code = value;
    end else begin
      sep_code = value;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. For every word it stalls a random number of cycles, then
  // drops stall until a word is taken. On request it holds off for a long
  // stretch so the job queue fills and the block stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : byte_sink
    int hold_taken;
    int wait_cycles;
    hold_taken = 0;
    @(posedge clk);
    forever begin
      wait_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
      if (hold_asks != hold_taken) begin
        hold_taken  = hold_asks;
        wait_cycles = HOLD_CYCLES;
      end
      if (wait_cycles > 0) begin
        byte_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      byte_stall <= 1'b0;
      do @(posedge clk); while (!byte_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker. Each accepted byte word is compared with the oldest owed one.
  // ---------------------------------------------------------------------------
  byte_word_t want;

  task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (owed_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing owed, expected none actual %p", $time, byte_word);
      end else begin
        want = owed_bytes.pop_front();
        check_field("byte_value", want.byte_value, byte_word.byte_value);
        check_field("is_data", 8'(want.is_data), 8'(byte_word.is_data));
        check_field("run_last", 8'(want.run_last), 8'(byte_word.run_last));
        check_field("stream_end", 8'(want.stream_end), 8'(byte_word.stream_end));
        check_field("bad_length", 8'(want.bad_length), 8'(byte_word.bad_length));
        check_field("bad_char", 8'(want.bad_char), 8'(byte_word.bad_char));
      end
    end
  end

  // Watchdog: counts cycles in which no channel moves a word.
  initial begin : watchdog
    int still_cycles;
    still_cycles = 0;
    while (still_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((char_valid && !char_stall) || (byte_valid && !byte_stall) ||
          (cfg_valid && cfg_ready)) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, the directed table on the reset settings, then random
  // phases, each opened by writing both registers while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    byte_word_t typed_word;
    logic [7:0] pad_next;
    logic [7:0] sep_next;
    bit         paused;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The directed rows run on the reset settings before any register is written.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      typed_word            = '0;
      typed_word.run_last   = 1'b1;
      typed_word.stream_end = 1'b1;
      typed_word.bad_length = DIRECTED[r].blen;
      typed_word.bad_char   = DIRECTED[r].bchar;
      tx_quiet              = (r < 10);
      send_word('{char_code: DIRECTED[r].code, end_of_input: DIRECTED[r].eoi},
                DIRECTED[r].typed, typed_word);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (p < NUM_PHASES - 1) begin
        {pad_next, sep_next} = PHASE_CFG[p];
      end else begin
        pad_next = 8'($urandom_range(0, 255));
        sep_next = 8'($urandom_range(0, 255));
      end
      write_reg(CFG_PAD, pad_next);
      write_reg(CFG_SEP, sep_next);
      cfg_valid <= 1'b0;

      // One phase drains every word without any receiver stall.
      rx_quiet = (p == 2);
      // In the second phase the receiver stops for a long while as the
      // sender keeps going, so the block's queue fills and stalls intake.
      if (p == 1) begin
        hold_asks++;
      end
      counted = 0;
      paused  = 1'b0;
      while (counted < PHASE_ITEMS) begin
        // Halfway through, the sender stops until every result has come.
        if (!paused && counted >= PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain();
        end
        send_stream();
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
